// ----- design/fqp_pkg.sv -----
package fqp_pkg;

  localparam int unsigned CNT_W = 32;
  localparam int unsigned OUT_CNT_W = 32;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic [2:0]           kind;
    logic [2:0]           error_code;
    logic [OUT_CNT_W-1:0] line_number;
    logic [OUT_CNT_W-1:0] column_number;
  } out_item_t;

  typedef enum logic [3:0] {
    CL_BLANK,
    CL_NEWLINE,
    CL_LBRACE,
    CL_RBRACE,
    CL_QUOTE,
    CL_COLON,
    CL_COMMA,
    CL_BSLASH,
    CL_OTHER,
    CL_END
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] chr;
  } mid_item_t;

  typedef enum logic [3:0] {
    PH_BEFORE_OBJ,
    PH_KEY_OPEN,
    PH_KEY_BODY,
    PH_AFTER_KEY,
    PH_VALUE_OPEN,
    PH_VALUE_BODY,
    PH_AFTER_VALUE,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    KIND_LAYOUT,
    KIND_KEY,
    KIND_VALUE,
    KIND_KEY_CLOSED,
    KIND_PAIR_CLOSED,
    KIND_OBJ_CLOSED,
    KIND_ERROR,
    KIND_IDLE
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_BRACE,
    ERR_QUOTE,
    ERR_COLON,
    ERR_COMMA_BRACE,
    ERR_EARLY_END
  } err_t;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_LBRACE  = 8'h7b;
  localparam logic [7:0] CH_RBRACE  = 8'h7d;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;

  // Wide counters show all ones once they no longer fit the output field.
  function automatic logic [OUT_CNT_W-1:0] clip_cnt(input logic [CNT_W-1:0] v);
    logic [63:0] ext;
    ext = 64'(v);
    return (|ext[63:OUT_CNT_W]) ? '1 : ext[OUT_CNT_W-1:0];
  endfunction

endpackage

// ----- design/fqp_front.sv -----
module fqp_front (
  input  logic                 in_valid,
  input  fqp_pkg::in_item_t    in_item,
  output logic                 mid_push,
  output fqp_pkg::mid_item_t   mid_item
);

  fqp_pkg::cls_t cls;

  always_comb begin
    if (in_item.end_of_input) begin
      cls = fqp_pkg::CL_END;
    end else begin
      case (in_item.in_byte)
        fqp_pkg::CH_SPACE, fqp_pkg::CH_TAB: cls = fqp_pkg::CL_BLANK;
        fqp_pkg::CH_NEWLINE: cls = fqp_pkg::CL_NEWLINE;
        fqp_pkg::CH_LBRACE:  cls = fqp_pkg::CL_LBRACE;
        fqp_pkg::CH_RBRACE:  cls = fqp_pkg::CL_RBRACE;
        fqp_pkg::CH_QUOTE:   cls = fqp_pkg::CL_QUOTE;
        fqp_pkg::CH_COLON:   cls = fqp_pkg::CL_COLON;
        fqp_pkg::CH_COMMA:   cls = fqp_pkg::CL_COMMA;
        fqp_pkg::CH_BSLASH:  cls = fqp_pkg::CL_BSLASH;
        default:             cls = fqp_pkg::CL_OTHER;
      endcase
    end
  end

  // The byte is echoed as zero on end of stream.
  assign mid_item.cls = cls;
  assign mid_item.chr = in_item.end_of_input ? 8'h00 : in_item.in_byte;
  assign mid_push     = in_valid;

endmodule

// ----- design/fqp_queue.sv -----
module fqp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fqp_pkg::mid_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output fqp_pkg::mid_item_t pop_item
);

  fqp_pkg::mid_item_t slot_r [2];
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_item = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("queue count out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) || (cnt_r == 2'd2) || (rd_ptr_r != wr_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

// ----- design/fqp_back.sv -----
module fqp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  fqp_pkg::mid_item_t  q_item,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output fqp_pkg::out_item_t  out_data
);

  fqp_pkg::phase_t phase_r, phase_nxt;
  fqp_pkg::err_t   err_r, err_nxt;
  logic            esc_r, esc_nxt;
  logic [fqp_pkg::CNT_W-1:0] line_r, line_nxt;
  logic [fqp_pkg::CNT_W-1:0] col_r, col_nxt;

  fqp_pkg::kind_t kind;
  logic           take;
  logic           blank;
  logic           fire;
  logic           closes;

  fqp_pkg::out_item_t res;
  fqp_pkg::out_item_t oq_r [2];
  logic       oq_rd_r, oq_wr_r;
  logic [1:0] oq_cnt_r, oq_cnt_nxt;
  logic       oq_pop;

  assign fire   = !q_empty && (oq_cnt_r != 2'd2);
  assign q_pop  = fire;
  assign blank  = q_item.cls inside {fqp_pkg::CL_BLANK, fqp_pkg::CL_NEWLINE};
  assign closes = (q_item.cls == fqp_pkg::CL_QUOTE) && !esc_r;

  // Next phase, escape flag and latched error.
  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    err_nxt   = err_r;
    if (phase_r inside {fqp_pkg::PH_ERROR, fqp_pkg::PH_DONE}) begin
      phase_nxt = phase_r;
    end else if (q_item.cls == fqp_pkg::CL_END) begin
      phase_nxt = fqp_pkg::PH_ERROR;
      err_nxt   = fqp_pkg::ERR_EARLY_END;
    end else begin
      case (phase_r)
        fqp_pkg::PH_BEFORE_OBJ: begin
          if (q_item.cls == fqp_pkg::CL_LBRACE) begin
            phase_nxt = fqp_pkg::PH_KEY_OPEN;
          end else if (!blank) begin
            phase_nxt = fqp_pkg::PH_ERROR;
            err_nxt   = fqp_pkg::ERR_BRACE;
          end
        end
        fqp_pkg::PH_KEY_OPEN, fqp_pkg::PH_VALUE_OPEN: begin
          if (q_item.cls == fqp_pkg::CL_QUOTE) begin
            esc_nxt   = 1'b0;
            phase_nxt = (phase_r == fqp_pkg::PH_KEY_OPEN) ? fqp_pkg::PH_KEY_BODY
                                                          : fqp_pkg::PH_VALUE_BODY;
          end else if (!blank) begin
            phase_nxt = fqp_pkg::PH_ERROR;
            err_nxt   = fqp_pkg::ERR_QUOTE;
          end
        end
        fqp_pkg::PH_KEY_BODY, fqp_pkg::PH_VALUE_BODY: begin
          if (closes) begin
            esc_nxt   = 1'b0;
            phase_nxt = (phase_r == fqp_pkg::PH_KEY_BODY) ? fqp_pkg::PH_AFTER_KEY
                                                          : fqp_pkg::PH_AFTER_VALUE;
          end else begin
            esc_nxt = (q_item.cls == fqp_pkg::CL_BSLASH);
          end
        end
        fqp_pkg::PH_AFTER_KEY: begin
          if (q_item.cls == fqp_pkg::CL_COLON) begin
            phase_nxt = fqp_pkg::PH_VALUE_OPEN;
          end else if (!blank) begin
            phase_nxt = fqp_pkg::PH_ERROR;
            err_nxt   = fqp_pkg::ERR_COLON;
          end
        end
        fqp_pkg::PH_AFTER_VALUE: begin
          if (q_item.cls == fqp_pkg::CL_COMMA) begin
            phase_nxt = fqp_pkg::PH_KEY_OPEN;
          end else if (q_item.cls == fqp_pkg::CL_RBRACE) begin
            phase_nxt = fqp_pkg::PH_DONE;
          end else if (!blank) begin
            phase_nxt = fqp_pkg::PH_ERROR;
            err_nxt   = fqp_pkg::ERR_COMMA_BRACE;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // Tag of the beat and whether the counters advance for it.
  always_comb begin
    kind = fqp_pkg::KIND_LAYOUT;
    take = 1'b0;
    if (phase_nxt == fqp_pkg::PH_ERROR) begin
      kind = fqp_pkg::KIND_ERROR;
    end else if (phase_r == fqp_pkg::PH_DONE) begin
      kind = fqp_pkg::KIND_IDLE;
    end else begin
      take = 1'b1;
      case (phase_r)
        fqp_pkg::PH_KEY_BODY: begin
          kind = closes ? fqp_pkg::KIND_KEY_CLOSED : fqp_pkg::KIND_KEY;
        end
        fqp_pkg::PH_VALUE_BODY: begin
          kind = closes ? fqp_pkg::KIND_PAIR_CLOSED : fqp_pkg::KIND_VALUE;
        end
        fqp_pkg::PH_AFTER_VALUE: begin
          kind = (q_item.cls == fqp_pkg::CL_RBRACE) ? fqp_pkg::KIND_OBJ_CLOSED
                                                    : fqp_pkg::KIND_LAYOUT;
        end
        default: begin
          kind = fqp_pkg::KIND_LAYOUT;
        end
      endcase
    end
  end

  always_comb begin
    line_nxt = line_r;
    col_nxt  = col_r;
    if (take) begin
      if (q_item.cls == fqp_pkg::CL_NEWLINE) begin
        if (line_r != '1) begin
          line_nxt = line_r + 1'b1;
        end
        col_nxt = fqp_pkg::CNT_W'(1);
      end else if (col_r != '1) begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_comb begin
    res.out_byte      = q_item.chr;
    res.kind          = kind;
    res.error_code    = (kind == fqp_pkg::KIND_ERROR) ? err_nxt : fqp_pkg::ERR_NONE;
    res.line_number   = fqp_pkg::clip_cnt(line_nxt);
    res.column_number = fqp_pkg::clip_cnt(col_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fqp_pkg::PH_BEFORE_OBJ;
      esc_r   <= 1'b0;
      err_r   <= fqp_pkg::ERR_NONE;
      line_r  <= fqp_pkg::CNT_W'(1);
      col_r   <= fqp_pkg::CNT_W'(1);
    end else if (fire) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      err_r   <= err_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
    end
  end

  // Two-entry result queue keeps the parser moving while a result waits.
  assign oq_pop     = out_pop && (oq_cnt_r != 2'd0);
  assign out_empty  = (oq_cnt_r == 2'd0);
  assign out_data   = oq_r[oq_rd_r];
  assign oq_cnt_nxt = oq_cnt_r + {1'b0, fire} - {1'b0, oq_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_rd_r  <= 1'b0;
      oq_wr_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (oq_pop) begin
        oq_rd_r <= ~oq_rd_r;
      end
      if (fire) begin
        oq_wr_r <= ~oq_wr_r;
      end
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      oq_r[oq_wr_r] <= res;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == fqp_pkg::PH_ERROR) |-> (err_r != fqp_pkg::ERR_NONE))
    else $error("error phase without a latched code");

  assert property (@(posedge clk) disable iff (!rst_n)
    fire && (res.kind == fqp_pkg::KIND_ERROR) |-> (res.error_code != fqp_pkg::ERR_NONE))
    else $error("error beat without a code");

  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == fqp_pkg::PH_DONE || phase_r == fqp_pkg::PH_ERROR) |=>
      ($stable(line_r) && $stable(col_r)))
    else $error("counters moved after parsing stopped");

  assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= 2'd2)
    else $error("result queue overflow");

endmodule

// ----- design/flat_quoted_pair_object_parser.sv -----
// Channel  Ports                          Beat accepted when
// -------  -----------------------------  -------------------------
// input    in_push, in_full, in_data      in_push && !in_full
// result   out_empty, out_pop, out_data   out_pop && !out_empty
//
// One byte per cycle is sustained while the result side keeps popping; a
// byte's result is registered in the middle queue after classification and
// then in the result queue after parsing, from which it can be popped. The parser step in the back end sets the rate.
// Reset is synchronous and active low, and it empties both queues.
// A stalled result side fills the result queue, then the middle queue, and
// only then raises in_full.
module flat_quoted_pair_object_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  fqp_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output fqp_pkg::out_item_t out_data
);

  logic               mid_push;
  fqp_pkg::mid_item_t mid_in;
  fqp_pkg::mid_item_t mid_out;
  logic               mid_empty;
  logic               mid_pop;

  fqp_front u_front (
    .in_valid (in_push),
    .in_item  (in_data),
    .mid_push (mid_push),
    .mid_item (mid_in)
  );

  fqp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_item (mid_in),
    .full      (in_full),
    .pop       (mid_pop),
    .empty     (mid_empty),
    .pop_item  (mid_out)
  );

  fqp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (mid_empty),
    .q_item    (mid_out),
    .q_pop     (mid_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ----- dv/tb.sv -----
module tb;
  import fqp_pkg::*;

  class pair_parse_checker;
    phase_t      phase;
    logic        esc;
    logic [63:0] line_cnt;
    logic [63:0] col_cnt;
    logic [63:0] cnt_max;
    err_t        latched;
    out_item_t   expected_q[$];
    int          mismatches;

    function new();
      phase      = PH_BEFORE_OBJ;
      esc        = 1'b0;
      line_cnt   = 64'd1;
      col_cnt    = 64'd1;
      cnt_max    = {64{1'b1}} >> (64 - CNT_W);
      latched    = ERR_NONE;
      mismatches = 0;
    endfunction

    static function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE;
    endfunction

    function logic [OUT_CNT_W-1:0] shown(logic [63:0] v);
      return ((v >> OUT_CNT_W) != 0) ? '1 : v[OUT_CNT_W-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Works out the result for one accepted input beat and queues it.
    function void note_input(in_item_t it);
      out_item_t  r;
      logic [7:0] b;
      kind_t      k;
      err_t       e;
      bit         take;
      b    = it.end_of_input ? 8'h00 : it.in_byte;
      k    = KIND_LAYOUT;
      e    = ERR_NONE;
      take = 1'b1;
      if (phase == PH_ERROR) begin
        k    = KIND_ERROR;
        take = 1'b0;
      end else if (phase == PH_DONE) begin
        k    = KIND_IDLE;
        take = 1'b0;
      end else if (it.end_of_input) begin
        latched = ERR_EARLY_END;
        phase   = PH_ERROR;
        k       = KIND_ERROR;
        take    = 1'b0;
      end else begin
        case (phase)
          PH_BEFORE_OBJ: begin
            if (b == CH_LBRACE) phase = PH_KEY_OPEN;
            else if (!is_blank(b)) e = ERR_BRACE;
          end
          PH_KEY_OPEN, PH_VALUE_OPEN: begin
            if (b == CH_QUOTE) begin
              esc = 1'b0;
              if (phase == PH_KEY_OPEN) phase = PH_KEY_BODY;
              else phase = PH_VALUE_BODY;
            end else if (!is_blank(b)) begin
              e = ERR_QUOTE;
            end
          end
          PH_KEY_BODY, PH_VALUE_BODY: begin
            if (b == CH_QUOTE && !esc) begin
              if (phase == PH_KEY_BODY) begin
                k     = KIND_KEY_CLOSED;
                phase = PH_AFTER_KEY;
              end else begin
                k     = KIND_PAIR_CLOSED;
                phase = PH_AFTER_VALUE;
              end
              esc = 1'b0;
            end else begin
              if (phase == PH_KEY_BODY) k = KIND_KEY;
              else k = KIND_VALUE;
              esc = (b == CH_BSLASH);
            end
          end
          PH_AFTER_KEY: begin
            if (b == CH_COLON) phase = PH_VALUE_OPEN;
            else if (!is_blank(b)) e = ERR_COLON;
          end
          default: begin
            if (b == CH_COMMA) begin
              phase = PH_KEY_OPEN;
            end else if (b == CH_RBRACE) begin
              k     = KIND_OBJ_CLOSED;
              phase = PH_DONE;
            end else if (!is_blank(b)) begin
              e = ERR_COMMA_BRACE;
            end
          end
        endcase
        if (e != ERR_NONE) begin
          latched = e;
          phase   = PH_ERROR;
          k       = KIND_ERROR;
          take    = 1'b0;
        end
      end
      if (take) begin
        if (b == CH_NEWLINE) begin
          if (line_cnt < cnt_max) line_cnt++;
          col_cnt = 64'd1;
        end else if (col_cnt < cnt_max) begin
          col_cnt++;
        end
      end
      r.out_byte      = b;
      r.kind          = k;
      r.error_code    = (k == KIND_ERROR) ? latched : ERR_NONE;
      r.line_number   = shown(line_cnt);
      r.column_number = shown(col_cnt);
      expected_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h with nothing pending", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
          got.error_code !== want.error_code || got.line_number !== want.line_number ||
          got.column_number !== want.column_number) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch (exp/got): byte %h/%h kind %0d/%0d err %0d/%0d line %0d/%0d col %0d/%0d",
                   want.out_byte, got.out_byte, want.kind, got.kind,
                   want.error_code, got.error_code, want.line_number, got.line_number,
                   want.column_number, got.column_number);
      end
    endfunction
  endclass

  localparam int OBJECT_BYTES = 1680;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_data;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_data;

  pair_parse_checker sb;
  in_item_t          stream[$];

  flat_quoted_pair_object_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void add_byte(logic [7:0] c, bit eoi = 1'b0);
    in_item_t it;
    it.in_byte      = c;
    it.end_of_input = eoi;
    stream.push_back(it);
  endfunction

  function automatic void add_layout();
    int n;
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) begin
      case ($urandom_range(2))
        0: add_byte(CH_SPACE);
        1: add_byte(CH_TAB);
        default: add_byte(CH_NEWLINE);
      endcase
    end
  endfunction

  // Emits a well-formed quoted string: a bare quote in the content is
  // always escaped, and a trailing backslash is never left before the close.
  function automatic void add_string(int max_len);
    int         n;
    bit         esc;
    logic [7:0] c;
    esc = 1'b0;
    if ($urandom_range(15) == 0) max_len = 40;
    n = $urandom_range(max_len);
    add_byte(CH_QUOTE);
    repeat (n) begin
      case ($urandom_range(15))
        0, 1: c = CH_BSLASH;
        2: c = CH_QUOTE;
        3: c = CH_NEWLINE;
        4: begin
          case ($urandom_range(3))
            0: c = CH_LBRACE;
            1: c = CH_RBRACE;
            2: c = CH_COLON;
            default: c = CH_COMMA;
          endcase
        end
        default: c = 8'($urandom_range(255));
      endcase
      if (c == CH_QUOTE && !esc) add_byte(CH_BSLASH);
      add_byte(c);
      esc = (c == CH_BSLASH);
    end
    if (esc) add_byte(8'h61);
    add_byte(CH_QUOTE);
  endfunction

  function automatic logic [7:0] junk_byte(logic [7:0] no_a, logic [7:0] no_b);
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (pair_parse_checker::is_blank(c) || c == no_a || c == no_b);
    return c;
  endfunction

  function automatic void build_stream();
    logic [7:0] lead [27] = '{
      CH_NEWLINE, CH_SPACE, CH_TAB, CH_LBRACE, CH_NEWLINE, CH_QUOTE, 8'h00, 8'hff,
      CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_BSLASH, CH_QUOTE, 8'h6b, CH_QUOTE, CH_TAB,
      CH_COLON, CH_SPACE, CH_QUOTE, CH_LBRACE, CH_RBRACE, CH_COLON, CH_COMMA, 8'h0d,
      CH_QUOTE, CH_SPACE, CH_COMMA};
    // The opening pair covers zero and all-ones content, an escaped quote,
    // a doubled backslash that still guards the next quote, separators and a
    // carriage return inside strings.
    foreach (lead[i]) add_byte(lead[i]);
    while (1) begin
      add_layout();
      add_string(6);
      add_layout();
      add_byte(CH_COLON);
      add_layout();
      add_string(10);
      add_layout();
      if (stream.size() >= OBJECT_BYTES) break;
      add_byte(CH_COMMA);
    end
    // Errors are sticky and there is one reset, so each run picks one ending.
    case ($urandom_range(4))
      0: add_byte(CH_RBRACE);
      1: begin
        add_byte(CH_COMMA);
        add_layout();
        add_byte(junk_byte(CH_QUOTE, CH_QUOTE));
      end
      2: begin
        add_byte(CH_COMMA);
        add_layout();
        add_string(6);
        add_layout();
        add_byte(junk_byte(CH_COLON, CH_COLON));
      end
      3: add_byte(junk_byte(CH_COMMA, CH_RBRACE));
      default: begin
        if ($urandom_range(1) == 0) begin
          add_byte(CH_COMMA);
          add_byte(CH_QUOTE);
          add_byte(8'h61);
        end
        add_byte(8'($urandom_range(255)), 1'b1);
      end
    endcase
    repeat (24) add_byte(8'($urandom_range(255)), ($urandom_range(3) == 0));
  endfunction

  task automatic drive_stream();
    int idx;
    idx = 0;
    foreach (stream[i]) begin
      while (!(idx >= 600 && idx < 900) && $urandom_range(99) < 34) begin
        in_push <= 1'b0;
        @(posedge clk);
      end
      in_push <= 1'b1;
      in_data <= stream[i];
      @(posedge clk);
      while (in_full) @(posedge clk);
      sb.note_input(stream[i]);
      idx++;
    end
    in_push <= 1'b0;
  endtask

  task automatic drain_results();
    int cycle_n;
    cycle_n = 0;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) sb.check_result(out_data);
      cycle_n++;
      out_pop <= (cycle_n > 1200 && cycle_n < 1700) || ($urandom_range(99) >= 34);
    end
  endtask

  initial begin
    rst_n   <= 1'b0;
    in_push <= 1'b0;
    in_data <= '0;
    out_pop <= 1'b0;
    sb = new();
    build_stream();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    fork
      drain_results();
    join_none
    drive_stream();
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
